/* rtl/gmca_pkg.sv */
// Shared constants, types and codes for the calibration averager.
package gmca_pkg;

  localparam int unsigned RD_W   = 10;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned NUM_CH = 5;
  localparam int unsigned CH_W   = $clog2(NUM_CH);
  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] SAMPLE_COUNT = CNT_W'(64);
  localparam logic [CNT_W-1:0] STOP_WINDOW  = CNT_W'(100);
  localparam logic [SUM_W-1:0] STOP_LIMIT   = SUM_W'(50);
  localparam logic [RD_W-1:0]  LOW_READING  = RD_W'(2);
  localparam logic [RD_W-1:0]  THRESH_RESET = RD_W'(16);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_CALIBRATE = 1'b0;
  localparam logic CMD_STOPWATCH = 1'b1;

  localparam logic [CH_W-1:0] CH_FWD = CH_W'(0);
  localparam logic [CH_W-1:0] CH_RFL = CH_W'(1);
  localparam logic [CH_W-1:0] CH_REF = CH_W'(2);
  localparam logic [CH_W-1:0] CH_MAG = CH_W'(3);
  localparam logic [CH_W-1:0] CH_PHS = CH_W'(4);
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

  typedef struct packed {
    logic            cmd;
    logic            active;
    logic            low;
    logic [RD_W-1:0] fwd;
    logic [RD_W-1:0] rfl;
    logic [RD_W-1:0] ref_rd;
    logic [RD_W-1:0] mag;
    logic [RD_W-1:0] phs;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [RD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'b001,
    ST_DIV_START = 3'b010,
    ST_DIV_WAIT  = 3'b100
  } back_state_t;

endpackage

/* rtl/gmca_front.sv */
// Front end: threshold register, item classification and the item queue.
module gmca_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_cmd,
  input  logic [gmca_pkg::RD_W-1:0]    in_forward_reading,
  input  logic [gmca_pkg::RD_W-1:0]    in_reflected_reading,
  input  logic [gmca_pkg::RD_W-1:0]    in_reference_reading,
  input  logic [gmca_pkg::RD_W-1:0]    in_magnitude_reading,
  input  logic [gmca_pkg::RD_W-1:0]    in_phase_reading,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gmca_pkg::RD_W-1:0]    cfg_activity_threshold,
  output logic                         q_valid,
  output gmca_pkg::item_t              q_item,
  input  logic                         q_pop
);

  logic [gmca_pkg::RD_W-1:0]   thr_r;
  gmca_pkg::item_t             mem_r [gmca_pkg::QDEPTH];
  gmca_pkg::item_t             item_in;
  logic [gmca_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gmca_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gmca_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        push_ok;
  logic                        pop_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gmca_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_activity_threshold;
    end
  end

  // classify: skip only when both forward and reflected sit below threshold
  always_comb begin
    item_in.cmd    = in_cmd;
    item_in.active = !((in_forward_reading < thr_r) && (in_reflected_reading < thr_r));
    item_in.low    = in_forward_reading < gmca_pkg::LOW_READING;
    item_in.fwd    = in_forward_reading;
    item_in.rfl    = in_reflected_reading;
    item_in.ref_rd = in_reference_reading;
    item_in.mag    = in_magnitude_reading;
    item_in.phs    = in_phase_reading;
  end

  assign in_full = (cnt_r == gmca_pkg::QCNT_W'(gmca_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == gmca_pkg::QPTR_W'(gmca_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + gmca_pkg::QPTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == gmca_pkg::QPTR_W'(gmca_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + gmca_pkg::QPTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + gmca_pkg::QCNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - gmca_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* rtl/gmca_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module gmca_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gmca_pkg::div_req_t  req,
  output gmca_pkg::div_rsp_t  rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [gmca_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [gmca_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [gmca_pkg::SUM_W-1:0]   quo_r, quo_nxt;
  logic [gmca_pkg::CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [gmca_pkg::CNT_W:0]     trial;
  logic [gmca_pkg::CNT_W:0]     diff;
  logic                         ge;

  assign trial = {rem_r, quo_r[gmca_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[gmca_pkg::CNT_W-1:0] : trial[gmca_pkg::CNT_W-1:0];
      quo_nxt  = {quo_r[gmca_pkg::SUM_W-2:0], ge};
      step_nxt = step_r + gmca_pkg::STEP_W'(1);
      if (step_r == gmca_pkg::STEP_W'(gmca_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[gmca_pkg::RD_W-1:0];

endmodule

/* rtl/gmca_back.sv */
// Back end: sums, window counter, averaging sequencer and result register.
module gmca_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  gmca_pkg::item_t            q_item,
  output logic                       q_pop,
  output gmca_pkg::div_req_t         div_req,
  input  gmca_pkg::div_rsp_t         div_rsp,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_calibration_done,
  output logic                       out_stop_detected,
  output logic [gmca_pkg::RD_W-1:0]  out_average_forward,
  output logic [gmca_pkg::RD_W-1:0]  out_average_reflected,
  output logic [gmca_pkg::RD_W-1:0]  out_average_reference,
  output logic [gmca_pkg::RD_W-1:0]  out_average_magnitude,
  output logic [gmca_pkg::RD_W-1:0]  out_average_phase
);

  gmca_pkg::back_state_t        state_r, state_nxt;
  logic [gmca_pkg::SUM_W-1:0]   sum_r [gmca_pkg::NUM_CH];
  logic [gmca_pkg::SUM_W-1:0]   sum_nxt [gmca_pkg::NUM_CH];
  logic [gmca_pkg::RD_W-1:0]    avg_r [gmca_pkg::NUM_CH];
  logic [gmca_pkg::RD_W-1:0]    avg_nxt [gmca_pkg::NUM_CH];
  logic [gmca_pkg::RD_W-1:0]    rd [gmca_pkg::NUM_CH];
  logic [gmca_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [gmca_pkg::CNT_W-1:0]   cnt_inc;
  logic [gmca_pkg::CNT_W-1:0]   div_n_r, div_n_nxt;
  logic [gmca_pkg::CH_W-1:0]    idx_r, idx_nxt;
  logic                         done_r, done_nxt;
  logic                         stop_r, stop_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [gmca_pkg::SUM_W-1:0]   fwd_low_sum;

  assign rd[gmca_pkg::CH_FWD] = q_item.fwd;
  assign rd[gmca_pkg::CH_RFL] = q_item.rfl;
  assign rd[gmca_pkg::CH_REF] = q_item.ref_rd;
  assign rd[gmca_pkg::CH_MAG] = q_item.mag;
  assign rd[gmca_pkg::CH_PHS] = q_item.phs;

  assign cnt_inc     = cnt_r + gmca_pkg::CNT_W'(1);
  assign fwd_low_sum = sum_r[gmca_pkg::CH_FWD] + gmca_pkg::SUM_W'(q_item.low);
  assign q_pop       = (state_r == gmca_pkg::ST_IDLE) && q_valid && !out_valid_r;

  assign div_req.start    = (state_r == gmca_pkg::ST_DIV_START);
  assign div_req.dividend = sum_r[idx_r];
  assign div_req.divisor  = div_n_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    div_n_nxt     = div_n_r;
    idx_nxt       = idx_r;
    done_nxt      = done_r;
    stop_nxt      = stop_r;
    out_valid_nxt = out_valid_r;
    for (int i = 0; i < gmca_pkg::NUM_CH; i++) begin
      sum_nxt[i] = sum_r[i];
      avg_nxt[i] = avg_r[i];
    end
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      gmca_pkg::ST_IDLE: begin
        if (q_pop) begin
          stop_nxt = 1'b0;
          unique case (q_item.cmd)
            gmca_pkg::CMD_CALIBRATE: begin
              done_nxt = 1'b0;
              if (q_item.active) begin
                for (int i = 0; i < gmca_pkg::NUM_CH; i++) begin
                  sum_nxt[i] = sum_r[i] + gmca_pkg::SUM_W'(rd[i]);
                end
                cnt_nxt = cnt_inc;
                if (cnt_inc >= gmca_pkg::SAMPLE_COUNT) begin
                  div_n_nxt = cnt_inc;
                  idx_nxt   = gmca_pkg::CH_FWD;
                  state_nxt = gmca_pkg::ST_DIV_START;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            gmca_pkg::CMD_STOPWATCH: begin
              // close the window: report, drop forward count, counter and done
              if (cnt_inc >= gmca_pkg::STOP_WINDOW) begin
                stop_nxt                    = fwd_low_sum > gmca_pkg::STOP_LIMIT;
                sum_nxt[gmca_pkg::CH_FWD]   = '0;
                cnt_nxt                     = '0;
                done_nxt                    = 1'b0;
              end else begin
                sum_nxt[gmca_pkg::CH_FWD]   = fwd_low_sum;
                cnt_nxt                     = cnt_inc;
              end
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      gmca_pkg::ST_DIV_START: begin
        state_nxt = gmca_pkg::ST_DIV_WAIT;
      end
      gmca_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          avg_nxt[idx_r] = div_rsp.quotient;
          if (idx_r == gmca_pkg::CH_LAST) begin
            for (int i = 0; i < gmca_pkg::NUM_CH; i++) begin
              sum_nxt[i] = '0;
            end
            cnt_nxt       = '0;
            done_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = gmca_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + gmca_pkg::CH_W'(1);
            state_nxt = gmca_pkg::ST_DIV_START;
          end
        end
      end
      default: begin
        state_nxt = gmca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmca_pkg::ST_IDLE;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < gmca_pkg::NUM_CH; i++) begin
        sum_r[i] <= '0;
        avg_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < gmca_pkg::NUM_CH; i++) begin
        sum_r[i] <= sum_nxt[i];
        avg_r[i] <= avg_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    div_n_r <= div_n_nxt;
    idx_r   <= idx_nxt;
  end

  assign out_empty             = !out_valid_r;
  assign out_calibration_done  = done_r;
  assign out_stop_detected     = stop_r;
  assign out_average_forward   = avg_r[gmca_pkg::CH_FWD];
  assign out_average_reflected = avg_r[gmca_pkg::CH_RFL];
  assign out_average_reference = avg_r[gmca_pkg::CH_REF];
  assign out_average_magnitude = avg_r[gmca_pkg::CH_MAG];
  assign out_average_phase     = avg_r[gmca_pkg::CH_PHS];

endmodule

/* rtl/gated_multichannel_calibration_averager.sv */
// Top level: two-entry item queue in front, averaging back end with serial divider.
// Flow: an ordinary item goes from the queue through the back end into the result register;
// an item that closes a calibrate window first runs five 17-step divisions in turn.
// The back end takes a new item only while idle and once the result register is free.
// Reset: synchronous active-low rst_n clears the control state, sums, averages and flags
// and sets the threshold to 16; queue storage and divider operands are not reset.
module gated_multichannel_calibration_averager (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic                       in_cmd,
  input  logic [gmca_pkg::RD_W-1:0]  in_forward_reading,
  input  logic [gmca_pkg::RD_W-1:0]  in_reflected_reading,
  input  logic [gmca_pkg::RD_W-1:0]  in_reference_reading,
  input  logic [gmca_pkg::RD_W-1:0]  in_magnitude_reading,
  input  logic [gmca_pkg::RD_W-1:0]  in_phase_reading,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_calibration_done,
  output logic                       out_stop_detected,
  output logic [gmca_pkg::RD_W-1:0]  out_average_forward,
  output logic [gmca_pkg::RD_W-1:0]  out_average_reflected,
  output logic [gmca_pkg::RD_W-1:0]  out_average_reference,
  output logic [gmca_pkg::RD_W-1:0]  out_average_magnitude,
  output logic [gmca_pkg::RD_W-1:0]  out_average_phase,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gmca_pkg::RD_W-1:0]  cfg_activity_threshold
);

  logic                 q_valid;
  logic                 q_pop;
  gmca_pkg::item_t      q_item;
  gmca_pkg::div_req_t   div_req;
  gmca_pkg::div_rsp_t   div_rsp;

  gmca_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_cmd                 (in_cmd),
    .in_forward_reading     (in_forward_reading),
    .in_reflected_reading   (in_reflected_reading),
    .in_reference_reading   (in_reference_reading),
    .in_magnitude_reading   (in_magnitude_reading),
    .in_phase_reading       (in_phase_reading),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_activity_threshold (cfg_activity_threshold),
    .q_valid                (q_valid),
    .q_item                 (q_item),
    .q_pop                  (q_pop)
  );

  gmca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gmca_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_item                (q_item),
    .q_pop                 (q_pop),
    .div_req               (div_req),
    .div_rsp               (div_rsp),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_calibration_done  (out_calibration_done),
    .out_stop_detected     (out_stop_detected),
    .out_average_forward   (out_average_forward),
    .out_average_reflected (out_average_reflected),
    .out_average_reference (out_average_reference),
    .out_average_magnitude (out_average_magnitude),
    .out_average_phase     (out_average_phase)
  );

endmodule

/* tb/tb_gated_multichannel_calibration_averager.sv */
// Self-checking testbench for the gated multichannel calibration averager.
`timescale 1ns / 100ps

module tb_gated_multichannel_calibration_averager;

  localparam int RD_W         = gmca_pkg::RD_W;
  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int CAL_WINDOW   = 64;
  localparam int STOP_SPAN    = 100;
  localparam int STOP_MIN     = 50;
  localparam int LOW_LIMIT    = 2;
  localparam int CHUNK_ITEMS  = 110;
  localparam int STALL_CYCLES = 300;
  localparam int SETTLE       = 100;
  localparam int MAX_SHOWN    = 10;
  localparam longint TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic            cmd;
    logic [RD_W-1:0] fwd;
    logic [RD_W-1:0] rfl;
    logic [RD_W-1:0] vref;
    logic [RD_W-1:0] mag;
    logic [RD_W-1:0] phs;
  } sample_t;

  typedef struct packed {
    logic                 done;
    logic                 stop;
    logic [4:0][RD_W-1:0] avg;
  } report_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_push = 1'b0;
  logic            in_full;
  logic            in_cmd = 1'b0;
  logic [RD_W-1:0] in_forward_reading = '0;
  logic [RD_W-1:0] in_reflected_reading = '0;
  logic [RD_W-1:0] in_reference_reading = '0;
  logic [RD_W-1:0] in_magnitude_reading = '0;
  logic [RD_W-1:0] in_phase_reading = '0;
  logic            out_empty;
  logic            out_pop = 1'b0;
  logic            out_calibration_done;
  logic            out_stop_detected;
  logic [RD_W-1:0] out_average_forward;
  logic [RD_W-1:0] out_average_reflected;
  logic [RD_W-1:0] out_average_reference;
  logic [RD_W-1:0] out_average_magnitude;
  logic [RD_W-1:0] out_average_phase;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [RD_W-1:0] cfg_activity_threshold = '0;

  gated_multichannel_calibration_averager dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_cmd                 (in_cmd),
    .in_forward_reading     (in_forward_reading),
    .in_reflected_reading   (in_reflected_reading),
    .in_reference_reading   (in_reference_reading),
    .in_magnitude_reading   (in_magnitude_reading),
    .in_phase_reading       (in_phase_reading),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_calibration_done   (out_calibration_done),
    .out_stop_detected      (out_stop_detected),
    .out_average_forward    (out_average_forward),
    .out_average_reflected  (out_average_reflected),
    .out_average_reference  (out_average_reference),
    .out_average_magnitude  (out_average_magnitude),
    .out_average_phase      (out_average_phase),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_activity_threshold (cfg_activity_threshold)
  );

  // Predictor state
  logic [RD_W-1:0]      thr = RD_W'(16);
  logic [16:0]          acc [5] = '{default: '0};
  logic [6:0]           cnt = '0;
  logic [4:0][RD_W-1:0] latched = '0;
  logic                 win_done = 1'b0;

  sample_t pending [$];
  report_t expected_reports [$];
  sample_t offered = '0;
  sample_t nxt;
  report_t want;
  logic    in_took = 1'b0;
  logic    rx_hold = 1'b0;
  int      in_idle_pct = 13;
  int      out_idle_pct = 61;
  int      items_in = 0;
  int      mismatches = 0;
  int      windows_closed = 0;
  int      stops_flagged = 0;
  int      cfg_writes = 0;

  always #HALF_PERIOD clk = ~clk;

  function automatic report_t calc_averages(sample_t s);
    report_t r;
    logic [RD_W-1:0] rd [5];
    rd = '{s.fwd, s.rfl, s.vref, s.mag, s.phs};
    r.stop = 1'b0;
    if (s.cmd == gmca_pkg::CMD_CALIBRATE) begin
      win_done = 1'b0;
      if (s.fwd >= thr || s.rfl >= thr) begin
        for (int i = 0; i < 5; i++) acc[i] = acc[i] + 17'(rd[i]);
        cnt = cnt + 7'd1;
        if (cnt >= CAL_WINDOW) begin
          for (int i = 0; i < 5; i++) begin
            latched[i] = RD_W'(acc[i] / 17'(cnt));
            acc[i] = '0;
          end
          cnt = '0;
          win_done = 1'b1;
        end
      end
    end else begin
      if (s.fwd < LOW_LIMIT) acc[0] = acc[0] + 17'd1;
      cnt = cnt + 7'd1;
      if (cnt >= STOP_SPAN) begin
        r.stop = (acc[0] > STOP_MIN);
        acc[0] = '0;
        cnt = '0;
        win_done = 1'b0;
      end
    end
    r.done = win_done;
    r.avg = latched;
    return r;
  endfunction

  task automatic note_failure(string msg);
    if (mismatches < MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val)
      note_failure($sformatf("%s expected %0d, got %0d", name, exp_val, act_val));
  endtask

  // Input beat tracking, prediction and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_push && !in_full;
      if (in_took) begin
        expected_reports.push_back(calc_averages(offered));
        items_in++;
      end
      if (out_pop && !out_empty) begin
        if (expected_reports.size() == 0) begin
          note_failure("result beat with no expectation waiting");
        end else begin
          want = expected_reports.pop_front();
          if (want.done) windows_closed++;
          if (want.stop) stops_flagged++;
          check_field("calibration_done", want.done, out_calibration_done);
          check_field("stop_detected", want.stop, out_stop_detected);
          check_field("average_forward", want.avg[0], out_average_forward);
          check_field("average_reflected", want.avg[1], out_average_reflected);
          check_field("average_reference", want.avg[2], out_average_reference);
          check_field("average_magnitude", want.avg[3], out_average_magnitude);
          check_field("average_phase", want.avg[4], out_average_phase);
        end
      end
    end
  end

  // Sender: advance to the next pending beat once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      if (pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = pending.pop_front();
        offered <= nxt;
        in_push <= 1'b1;
        in_cmd <= nxt.cmd;
        in_forward_reading <= nxt.fwd;
        in_reflected_reading <= nxt.rfl;
        in_reference_reading <= nxt.vref;
        in_magnitude_reading <= nxt.mag;
        in_phase_reading <= nxt.phs;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    out_pop <= rst_n && !rx_hold && ($urandom_range(99) >= out_idle_pct);
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (items_in >= 60);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #TIMEOUT_NS;
    $display("gated_multichannel_calibration_averager test failed");
    $finish;
  end

  task automatic add(logic c, logic [RD_W-1:0] f, logic [RD_W-1:0] r, logic [RD_W-1:0] v,
                     logic [RD_W-1:0] m, logic [RD_W-1:0] p);
    pending.push_back('{cmd: c, fwd: f, rfl: r, vref: v, mag: m, phs: p});
  endtask

  function automatic logic [RD_W-1:0] rand_reading();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 25) return RD_W'(1);
    if (pick < 30) return RD_W'(2);
    return RD_W'($urandom_range(1023, 0));
  endfunction

  task automatic drain();
    while (pending.size() != 0 || in_push || expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [RD_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_activity_threshold <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thr = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly whole calibrate and stop-watch windows, plus noise and skipped beats
  task automatic queue_chunk(int n);
    int added;
    int kind;
    int len;
    int low_pct;
    logic maxed;
    logic [RD_W-1:0] f;
    logic [RD_W-1:0] r;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        len = $urandom_range(72, 56);
        maxed = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
          if (maxed) begin
            add(gmca_pkg::CMD_CALIBRATE, '1, '1, '1, '1, '1);
          end else if (thr != 0 && $urandom_range(99) < 12) begin
            add(gmca_pkg::CMD_CALIBRATE, RD_W'($urandom_range(thr - 1, 0)),
                RD_W'($urandom_range(thr - 1, 0)), rand_reading(), rand_reading(),
                rand_reading());
          end else begin
            if ($urandom_range(1) == 1) begin
              f = RD_W'($urandom_range(1023, thr));
              r = rand_reading();
            end else begin
              r = RD_W'($urandom_range(1023, thr));
              f = rand_reading();
            end
            add(gmca_pkg::CMD_CALIBRATE, f, r, rand_reading(), rand_reading(), rand_reading());
          end
        end
      end else if (kind < 75) begin
        len = $urandom_range(110, 90);
        low_pct = $urandom_range(100, 0);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < low_pct) f = RD_W'($urandom_range(1, 0));
          else f = rand_reading();
          add(gmca_pkg::CMD_STOPWATCH, f, rand_reading(), rand_reading(), rand_reading(),
              rand_reading());
        end
      end else begin
        len = $urandom_range(20, 4);
        for (int k = 0; k < len; k++)
          add(logic'($urandom_range(1)), rand_reading(), rand_reading(), rand_reading(),
              rand_reading(), rand_reading());
      end
      added += len;
    end
  endtask

  initial begin
    int thr_plan [6];
    thr_plan = '{0, 1023, $urandom_range(1023), 16, 1, $urandom_range(64)};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: threshold edges, reading extremes, both modes
    add(gmca_pkg::CMD_CALIBRATE, 0, 0, 0, 0, 0);
    add(gmca_pkg::CMD_CALIBRATE, 15, 15, 1023, 1023, 1023);
    add(gmca_pkg::CMD_CALIBRATE, 16, 0, 0, 0, 0);
    add(gmca_pkg::CMD_CALIBRATE, 0, 16, 1, 2, 3);
    add(gmca_pkg::CMD_CALIBRATE, 1023, 1023, 1023, 1023, 1023);
    add(gmca_pkg::CMD_CALIBRATE, 1023, 0, 0, 0, 0);
    add(gmca_pkg::CMD_CALIBRATE, 0, 1023, 1023, 0, 1023);
    add(gmca_pkg::CMD_CALIBRATE, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
    add(gmca_pkg::CMD_STOPWATCH, 0, 0, 0, 0, 0);
    add(gmca_pkg::CMD_STOPWATCH, 1, 1023, 1023, 1023, 1023);
    add(gmca_pkg::CMD_STOPWATCH, 2, 0, 0, 0, 0);
    add(gmca_pkg::CMD_STOPWATCH, 1023, 1023, 1023, 1023, 1023);
    add(gmca_pkg::CMD_STOPWATCH, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    add(gmca_pkg::CMD_CALIBRATE, 17, 17, 17, 17, 17);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin in_idle_pct = 13; out_idle_pct = 61; end
        1: begin in_idle_pct = 61; out_idle_pct = 13; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      cfg_write(RD_W'(thr_plan[ph]));
      queue_chunk(CHUNK_ITEMS);
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_reports.size()));
    $display("Covered %0d input beats over %0d threshold settings and three idle patterns;",
             items_in, cfg_writes);
    $display("saw %0d closed calibration windows and %0d stop detections.",
             windows_closed, stops_flagged);
    if (mismatches == 0) begin
      $display("gated_multichannel_calibration_averager test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("gated_multichannel_calibration_averager test failed");
    end
    $finish;
  end

endmodule
